### sv/sos_pkg.sv
// ----------------------------------------------------------------------------
// sos_pkg
// Shared widths, register indexes, reset values and result codes for the
// sweep object segmenter.
// ----------------------------------------------------------------------------
package sos_pkg;

	localparam int unsigned DIST_IN_W  = 12;
	localparam int unsigned DIST_W     = 11;
	localparam int unsigned ANGLE_W    = 8;
	localparam int unsigned INDEX_W    = 7;
	localparam int unsigned COUNT_W    = 5;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 11;

	localparam int unsigned SAMPLES_DEF     = 91;
	localparam int unsigned MAX_OBJECTS_DEF = 25;

	localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_CLAMP = 3'd3;

	localparam logic [DIST_W-1:0]  EDGE_THRESHOLD_RST = 11'd160;
	localparam logic [ANGLE_W-1:0] MIN_WIDTH_RST      = 8'd4;
	localparam logic [DIST_W-1:0]  NEAR_LIMIT_RST     = 11'd160;
	localparam logic [DIST_W-1:0]  DISTANCE_CLAMP_RST = 11'd1360;

	localparam logic [ANGLE_W-1:0] STRAIGHT_ANGLE = 8'd90;

	localparam logic KIND_OBJECT  = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [ANGLE_W-1:0] start_angle;
		logic [ANGLE_W-1:0] end_angle;
		logic [DIST_W-1:0]  object_distance;
		logic [COUNT_W-1:0] object_count;
		logic [ANGLE_W-1:0] turn_angle;
		logic               near_flag;
		logic               found_flag;
		logic               overflow_flag;
	} result_t;

endpackage

### sv/sos_sample_if.sv
// ----------------------------------------------------------------------------
// sos_sample_if
// Valid/ready channel carrying one range sample per transaction.
// ----------------------------------------------------------------------------
interface sos_sample_if import sos_pkg::*; ();

	logic                 valid;
	logic                 ready;
	logic [DIST_IN_W-1:0] ir_distance;
	logic [DIST_IN_W-1:0] ping_distance;

	modport source (output valid, output ir_distance, output ping_distance, input ready);
	modport sink   (input valid, input ir_distance, input ping_distance, output ready);

endinterface

### sv/sos_result_if.sv
// ----------------------------------------------------------------------------
// sos_result_if
// Valid/ready channel carrying one object record or sweep summary.
// ----------------------------------------------------------------------------
interface sos_result_if import sos_pkg::*; ();

	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic        [ANGLE_W-1:0] start_angle;
	logic        [ANGLE_W-1:0] end_angle;
	logic        [DIST_W-1:0]  object_distance;
	logic        [COUNT_W-1:0] object_count;
	logic signed [ANGLE_W-1:0] turn_angle;
	logic                      near_flag;
	logic                      found_flag;
	logic                      overflow_flag;

	modport source (
		output valid, output kind, output start_angle, output end_angle,
		output object_distance, output object_count, output turn_angle,
		output near_flag, output found_flag, output overflow_flag,
		input ready
	);
	modport sink (
		input valid, input kind, input start_angle, input end_angle,
		input object_distance, input object_count, input turn_angle,
		input near_flag, input found_flag, input overflow_flag,
		output ready
	);

endinterface

### sv/sweep_object_segmenter.sv
// ----------------------------------------------------------------------------
// sweep_object_segmenter
// Segments a range sweep into objects, reports each one and then the narrowest.
// ----------------------------------------------------------------------------
// One sample transaction is taken per clock; any result it yields (an object
// record or, on the last sample of a sweep, the summary) appears in the result
// register on the next cycle. The result register is the only stage, so a new
// sample is taken in the same cycle as the previous result is consumed; the
// input stalls only while a result is held there and not taken. Register
// writes apply from the next sample on.
module sweep_object_segmenter import sos_pkg::*; #(
	parameter int unsigned SAMPLES     = SAMPLES_DEF,
	parameter int unsigned MAX_OBJECTS = MAX_OBJECTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	sos_sample_if.sink            samples,
	sos_result_if.source          results
);

	localparam logic [INDEX_W-1:0] LAST_IDX    = INDEX_W'(SAMPLES - 1);
	localparam logic [INDEX_W-1:0] WIN_LAST    = INDEX_W'(SAMPLES - 2);
	localparam logic [INDEX_W-1:0] WIN_FIRST   = INDEX_W'(2);
	localparam logic [COUNT_W-1:0] MAX_OBJ_CNT = COUNT_W'(MAX_OBJECTS);

	logic [DIST_W-1:0]  edge_threshold_q, near_limit_q, distance_clamp_q;
	logic [ANGLE_W-1:0] min_width_q;

	logic [DIST_W-1:0]  ir_older_q, ir_newer_q, ping_newer_q;
	logic [INDEX_W-1:0] sample_index_q;
	logic               inside_object_q;
	logic [ANGLE_W-1:0] opening_angle_q;
	logic [COUNT_W-1:0] recorded_count_q;
	logic [ANGLE_W-1:0] best_width_q, best_start_q, best_end_q;
	logic [DIST_W-1:0]  best_distance_q;
	logic               dropped_q;

	logic    out_valid_q;
	result_t res_q, res_d;

	logic               in_fire;
	logic [DIST_W-1:0]  ir_sat, ping_sat;
	logic               in_window, is_last;
	logic [INDEX_W-1:0] mid;
	logic [ANGLE_W-1:0] angle, width;
	logic               drop, rise, wide, do_open, do_close, room, record, better;
	logic [ANGLE_W:0]   centre_sum;
	logic [ANGLE_W-1:0] centre;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_threshold_q <= EDGE_THRESHOLD_RST;
			min_width_q      <= MIN_WIDTH_RST;
			near_limit_q     <= NEAR_LIMIT_RST;
			distance_clamp_q <= DISTANCE_CLAMP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_EDGE_THRESHOLD: edge_threshold_q <= cfg_data[DIST_W-1:0];
				REG_MIN_WIDTH:      min_width_q      <= cfg_data[ANGLE_W-1:0];
				REG_NEAR_LIMIT:     near_limit_q     <= cfg_data[DIST_W-1:0];
				REG_DISTANCE_CLAMP: distance_clamp_q <= cfg_data[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_fire       = samples.valid && samples.ready;
	assign samples.ready = !out_valid_q || results.ready;

	assign ir_sat   = (samples.ir_distance > {1'b0, distance_clamp_q}) ?
		distance_clamp_q : samples.ir_distance[DIST_W-1:0];
	assign ping_sat = (samples.ping_distance > {1'b0, distance_clamp_q}) ?
		distance_clamp_q : samples.ping_distance[DIST_W-1:0];

	assign in_window = (sample_index_q >= WIN_FIRST) && (sample_index_q <= WIN_LAST);
	assign is_last   = sample_index_q >= LAST_IDX;
	assign mid       = sample_index_q - INDEX_W'(1);
	assign angle     = {mid, 1'b0};

	assign drop = {1'b0, ir_older_q} > ({1'b0, ir_sat} + {1'b0, edge_threshold_q});
	assign rise = {1'b0, ir_sat} > ({1'b0, ir_older_q} + {1'b0, edge_threshold_q});
	assign wide = {1'b0, angle} > ({1'b0, opening_angle_q} + {1'b0, min_width_q});

	assign do_open  = in_window && drop && !inside_object_q;
	assign do_close = in_window && !drop && rise && inside_object_q;
	assign room     = recorded_count_q < MAX_OBJ_CNT;
	assign record   = do_close && wide && room;
	assign width    = angle - opening_angle_q;
	assign better   = width < best_width_q;

	assign centre_sum = {1'b0, best_start_q} + {1'b0, best_end_q};
	assign centre     = centre_sum[ANGLE_W:1];

	always_comb begin
		res_d = '0;
		if (record) begin
			res_d.kind            = KIND_OBJECT;
			res_d.start_angle     = opening_angle_q;
			res_d.end_angle       = angle;
			res_d.object_distance = ping_newer_q;
			res_d.object_count    = recorded_count_q + COUNT_W'(1);
		end
		if (is_last) begin
			res_d.kind          = KIND_SUMMARY;
			res_d.object_count  = recorded_count_q;
			res_d.found_flag    = recorded_count_q != '0;
			res_d.overflow_flag = dropped_q;
			if (recorded_count_q != '0) begin
				res_d.start_angle     = best_start_q;
				res_d.end_angle       = best_end_q;
				res_d.object_distance = best_distance_q;
				res_d.turn_angle      = STRAIGHT_ANGLE - centre;
				res_d.near_flag       = best_distance_q < near_limit_q;
			end
		end
	end

	// sweep state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ir_older_q       <= '0;
			ir_newer_q       <= '0;
			ping_newer_q     <= '0;
			sample_index_q   <= '0;
			inside_object_q  <= 1'b0;
			opening_angle_q  <= '0;
			recorded_count_q <= '0;
			best_width_q     <= '1;
			best_start_q     <= '0;
			best_end_q       <= '0;
			best_distance_q  <= '0;
			dropped_q        <= 1'b0;
		end else if (in_fire) begin
			ir_older_q   <= ir_newer_q;
			ir_newer_q   <= ir_sat;
			ping_newer_q <= ping_sat;
			if (is_last) begin
				sample_index_q   <= '0;
				inside_object_q  <= 1'b0;
				opening_angle_q  <= '0;
				recorded_count_q <= '0;
				best_width_q     <= '1;
				best_start_q     <= '0;
				best_end_q       <= '0;
				best_distance_q  <= '0;
				dropped_q        <= 1'b0;
			end else begin
				sample_index_q <= sample_index_q + INDEX_W'(1);
				if (do_open) begin
					inside_object_q <= 1'b1;
					opening_angle_q <= angle;
				end
				if (do_close) begin
					inside_object_q <= 1'b0;
				end
				if (do_close && wide && !room) begin
					dropped_q <= 1'b1;
				end
				if (record) begin
					recorded_count_q <= recorded_count_q + COUNT_W'(1);
					if (better) begin
						best_width_q    <= width;
						best_start_q    <= opening_angle_q;
						best_end_q      <= angle;
						best_distance_q <= ping_newer_q;
					end
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= record || is_last;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q <= res_d;
		end
	end

	assign results.valid           = out_valid_q;
	assign results.kind            = res_q.kind;
	assign results.start_angle     = res_q.start_angle;
	assign results.end_angle       = res_q.end_angle;
	assign results.object_distance = res_q.object_distance;
	assign results.object_count    = res_q.object_count;
	assign results.turn_angle      = res_q.turn_angle;
	assign results.near_flag       = res_q.near_flag;
	assign results.found_flag      = res_q.found_flag;
	assign results.overflow_flag   = res_q.overflow_flag;

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		sample_index_q <= LAST_IDX)
		else $error("sample index beyond last sample");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		recorded_count_q <= MAX_OBJ_CNT)
		else $error("recorded object count beyond store size");

	a_sweep_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && is_last |=> sample_index_q == '0 && recorded_count_q == '0 && !dropped_q)
		else $error("sweep state not cleared after summary");

	a_found_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.kind == KIND_SUMMARY |-> res_q.found_flag == (res_q.object_count != '0))
		else $error("summary found flag disagrees with object count");

endmodule
